>>> hw/rtl/otsu_pkg.sv
// Shared constants and types for the Otsu threshold block.
`default_nettype none
package otsu_pkg;

  localparam int PIXEL_COUNT_BITS = 22;
  localparam int NUM_BINS = 256;
  localparam int BIN_W = 8;
  localparam int CNT_W = PIXEL_COUNT_BITS + 1;
  localparam int SUM_W = CNT_W + BIN_W;
  localparam int D_W = SUM_W + CNT_W;
  localparam int Q_W = 2 * CNT_W;
  localparam int MA_W = 2 * D_W;
  localparam int MB_W = D_W;
  localparam int DIG_W = 8;
  localparam int NDIG = (MB_W + DIG_W - 1) / DIG_W;
  localparam int P_W = MA_W + MB_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  // one pixel request as queued between front and back
  typedef struct packed {
    logic [BIN_W-1:0] pix;
    logic             cnt_en;
    logic             last;
    logic [CNT_W-1:0] tot;
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } px_req_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic           done;
    logic [P_W-1:0] p;
  } mul_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/otsu_threshold_top.sv
// Top level of the Otsu threshold block.
// Input channel: pixel_i (8-bit gray value) and last_i, valid/ready handshake.
// Output channel: threshold_o and too_many_o, one result per image, valid/ready.
// While the queue has room, pixels are taken one per cycle into a 4-entry
// request queue and counted into a 256-bin histogram, one bin update per
// cycle while the queue holds pixels and no scan runs. At most 2^22 pixels
// are counted per image; later ones are dropped and reported on too_many_o.
// After the last pixel the back end scans the bins; each bin with both class
// weights nonzero takes three passes through the shared 8-bit-digit
// multiplier. During the scan the queue fills and in_ready_o drops until
// the next image can be counted.
// The result waits in an output register; a stalled receiver holds it and
// the next scan finishes only after it was taken. The histogram is cleared
// at once when the result is loaded. Reset empties the queue, clears the
// histogram valid bits and the counts, and drops out_valid_o.
`default_nettype none
module otsu_threshold_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] threshold_o,
  output logic       too_many_o
);
  import otsu_pkg::*;

  px_req_t  push_data, head;
  logic     push, pop, full, empty;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  otsu_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .pixel_i, .last_i,
    .full_i(full), .push_o(push), .push_data_o(push_data)
  );

  otsu_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .full_o(full),
    .pop_i(pop), .data_o(head), .empty_o(empty)
  );

  otsu_mul u_mul (
    .clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp)
  );

  otsu_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .mul_req_o(mul_req), .mul_rsp_i(mul_rsp),
    .out_valid_o, .out_ready_i, .threshold_o, .too_many_o
  );

endmodule
`default_nettype wire

>>> hw/rtl/otsu_front.sv
// Front end: takes pixels, applies the count bound, keeps pixel total and weighted sum.
`default_nettype none
module otsu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [otsu_pkg::BIN_W-1:0]    pixel_i,
  input  logic                          last_i,
  input  logic                          full_i,
  output logic                          push_o,
  output otsu_pkg::px_req_t             push_data_o
);
  import otsu_pkg::*;

  logic [CNT_W-1:0] tot_q, tot_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic             cnt_en;
  logic             acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  // total below 2^PIXEL_COUNT_BITS exactly when its top bit is clear
  assign cnt_en     = !tot_q[CNT_W-1];

  assign tot_d = cnt_en ? tot_q + CNT_W'(1) : tot_q;
  assign sum_d = cnt_en ? sum_q + SUM_W'(pixel_i) : sum_q;
  assign ovf_d = ovf_q | !cnt_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (acc) begin
      if (last_i) begin
        tot_q <= '0;
        sum_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        tot_q <= tot_d;
        sum_q <= sum_d;
        ovf_q <= ovf_d;
      end
    end
  end

  assign push_o             = acc;
  assign push_data_o.pix    = pixel_i;
  assign push_data_o.cnt_en = cnt_en;
  assign push_data_o.last   = last_i;
  assign push_data_o.tot    = tot_d;
  assign push_data_o.sum    = sum_d;
  assign push_data_o.ovf    = ovf_d;

endmodule
`default_nettype wire

>>> hw/rtl/otsu_fifo.sv
// Short request queue between front end and back end.
`default_nettype none
module otsu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  otsu_pkg::px_req_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output otsu_pkg::px_req_t data_o,
  output logic              empty_o
);
  import otsu_pkg::*;

  px_req_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/otsu_mul.sv
// Digit-serial multiplier, one 8-bit digit of b per cycle, MSB digit first.
`default_nettype none
module otsu_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  otsu_pkg::mul_req_t req_i,
  output otsu_pkg::mul_rsp_t rsp_o
);
  import otsu_pkg::*;

  localparam int CNT_BITS = $clog2(NDIG + 1);
  localparam int BP_W = NDIG * DIG_W;

  logic [MA_W-1:0]       a_q;
  logic [BP_W-1:0]       b_q;
  logic [P_W-1:0]        acc_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  done_q;
  logic [DIG_W-1:0]      dig;
  logic [MA_W+DIG_W-1:0] pp;

  assign dig = b_q[BP_W-1 -: DIG_W];
  assign pp  = a_q * dig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_BITS'(1));
      if (req_i.start)       cnt_q <= CNT_BITS'(NDIG);
      else if (cnt_q != '0)  cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= BP_W'(req_i.b);
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[P_W-DIG_W-1:0], DIG_W'(0)} + P_W'(pp);
      b_q   <= b_q << DIG_W;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule
`default_nettype wire

>>> hw/rtl/otsu_back.sv
// Back end: histogram update, threshold scan sequencer and result register.
`default_nettype none
module otsu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  otsu_pkg::px_req_t          head_i,
  output logic                       pop_o,
  output otsu_pkg::mul_req_t         mul_req_o,
  input  otsu_pkg::mul_rsp_t         mul_rsp_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [otsu_pkg::BIN_W-1:0] threshold_o,
  output logic                       too_many_o
);
  import otsu_pkg::*;

  typedef enum logic [3:0] {
    ST_HIST, ST_DRAIN, ST_RD, ST_ACC, ST_PROD, ST_DIFF, ST_MGO, ST_MWT, ST_CMP, ST_DONE
  } state_e;

  typedef enum logic [1:0] {OP_SQ, OP_LHS, OP_RHS} mop_e;

  state_e            state_q;
  mop_e              op_q;
  logic              out_valid_q;
  logic [BIN_W-1:0]  threshold_q;
  logic              too_many_q;
  logic [NUM_BINS-1:0] vld_q;
  logic              s1_vld_q, fw_vld_q;

  logic [CNT_W-1:0]  hist_mem [NUM_BINS];
  logic [CNT_W-1:0]  rd_q;
  logic [BIN_W-1:0]  rd_addr;
  logic [BIN_W-1:0]  s1_pix_q, fw_pix_q;
  logic [CNT_W-1:0]  fw_cnt_q, s1_cur, s1_cnt;

  logic [CNT_W-1:0]  tot_q, wb_q, wf_q, bin_cnt, wb_d, wf_d;
  logic [SUM_W-1:0]  sum_q, sb_q, bin_wt;
  logic              ovf_q;
  logic [BIN_W-1:0]  bin_q, thr_q;
  logic [D_W-1:0]    a_q, b_q, d_q;
  logic [Q_W-1:0]    q_q, bq_q;
  logic [MA_W-1:0]   d2_q, bd2_q;
  logic [P_W-1:0]    lhs_q, rhs_q;

  assign pop_o   = (state_q == ST_HIST) && !empty_i;
  assign rd_addr = (state_q == ST_HIST) ? head_i.pix : bin_q;

  // newest write is not yet visible in the registered read data
  assign s1_cur = (fw_vld_q && fw_pix_q == s1_pix_q) ? fw_cnt_q :
                  (vld_q[s1_pix_q] ? rd_q : '0);
  assign s1_cnt = s1_cur + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    rd_q <= hist_mem[rd_addr];
    if (s1_vld_q) hist_mem[s1_pix_q] <= s1_cnt;
  end

  assign bin_cnt = vld_q[bin_q] ? rd_q : '0;
  assign wb_d    = wb_q + bin_cnt;
  assign wf_d    = tot_q - wb_d;
  assign bin_wt  = bin_q * bin_cnt;

  always_comb begin
    mul_req_o.start = (state_q == ST_MGO);
    case (op_q)
      OP_LHS: begin
        mul_req_o.a = d2_q;
        mul_req_o.b = MB_W'(bq_q);
      end
      OP_RHS: begin
        mul_req_o.a = bd2_q;
        mul_req_o.b = MB_W'(q_q);
      end
      default: begin
        mul_req_o.a = MA_W'(d_q);
        mul_req_o.b = d_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HIST;
      op_q        <= OP_SQ;
      out_valid_q <= 1'b0;
      threshold_q <= '0;
      too_many_q  <= 1'b0;
      vld_q       <= '0;
      s1_vld_q    <= 1'b0;
      fw_vld_q    <= 1'b0;
    end else begin
      s1_vld_q <= pop_o && head_i.cnt_en;
      fw_vld_q <= s1_vld_q;
      if (s1_vld_q) vld_q[s1_pix_q] <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_HIST: begin
          if (pop_o && head_i.last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: state_q <= ST_RD;
        ST_RD:    state_q <= ST_ACC;
        ST_ACC: begin
          if (wb_d == '0)      state_q <= (&bin_q) ? ST_DONE : ST_RD;
          else if (wf_d == '0) state_q <= ST_DONE;
          else                 state_q <= ST_PROD;
        end
        ST_PROD: state_q <= ST_DIFF;
        ST_DIFF: begin
          op_q    <= OP_SQ;
          state_q <= ST_MGO;
        end
        ST_MGO: state_q <= ST_MWT;
        ST_MWT: begin
          if (mul_rsp_i.done) begin
            unique case (op_q)
              OP_SQ: begin
                op_q    <= OP_LHS;
                state_q <= ST_MGO;
              end
              OP_LHS: begin
                op_q    <= OP_RHS;
                state_q <= ST_MGO;
              end
              default: state_q <= ST_CMP;
            endcase
          end
        end
        ST_CMP: state_q <= (&bin_q) ? ST_DONE : ST_RD;
        ST_DONE: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            threshold_q <= thr_q;
            too_many_q  <= ovf_q;
            vld_q       <= '0;
            state_q     <= ST_HIST;
          end
        end
        default: state_q <= ST_HIST;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q <= head_i.pix;
    fw_pix_q <= s1_pix_q;
    fw_cnt_q <= s1_cnt;
    if (pop_o && head_i.last) begin
      tot_q <= head_i.tot;
      sum_q <= head_i.sum;
      ovf_q <= head_i.ovf;
    end
    case (state_q)
      ST_DRAIN: begin
        bin_q <= '0;
        wb_q  <= '0;
        sb_q  <= '0;
        bd2_q <= '0;
        bq_q  <= Q_W'(1);
        thr_q <= '0;
      end
      ST_ACC: begin
        wb_q <= wb_d;
        wf_q <= wf_d;
        sb_q <= sb_q + bin_wt;
        if (wb_d == '0) bin_q <= bin_q + BIN_W'(1);
      end
      ST_PROD: begin
        a_q <= sb_q * tot_q;
        b_q <= sum_q * wb_q;
        q_q <= wb_q * wf_q;
      end
      ST_DIFF: d_q <= (a_q >= b_q) ? a_q - b_q : b_q - a_q;
      ST_MWT: begin
        if (mul_rsp_i.done) begin
          case (op_q)
            OP_SQ:   d2_q  <= mul_rsp_i.p[MA_W-1:0];
            OP_LHS:  lhs_q <= mul_rsp_i.p;
            default: rhs_q <= mul_rsp_i.p;
          endcase
        end
      end
      ST_CMP: begin
        if (lhs_q > rhs_q) begin
          bd2_q <= d2_q;
          bq_q  <= q_q;
          thr_q <= bin_q;
        end
        bin_q <= bin_q + BIN_W'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign threshold_o = threshold_q;
  assign too_many_o  = too_many_q;

endmodule
`default_nettype wire

>>> hw/rtl/otsu_checker.sv
// Port-level checks for the Otsu threshold block, bound to the top level.
`default_nettype none
module otsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] pixel_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] threshold_o,
  input logic       too_many_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(threshold_o) && $stable(too_many_o))
    else $error("result changed while stalled");

  // a scan always lies between two results
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("results back to back");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result right after reset");

endmodule

bind otsu_threshold_top otsu_checker u_chk (.*);
`default_nettype wire
